FILE: hdl/kfsp_pkg.sv
// Package for the keyframe sequence player: sizes, codes, row type and the cosine ease table.
// Depends on nothing; every other file of the block imports it.
package kfsp_pkg;

   localparam int MAX_KEYFRAMES = 16;
   localparam int KEY_IDX_W     = $clog2(MAX_KEYFRAMES);
   localparam int COUNT_W       = 5;
   localparam int COS_BITS      = 8;
   localparam int COS_TABLE_SIZE = 1 << COS_BITS;

   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(2);

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   localparam logic [2:0] MODE_LINEAR = 3'd1;
   localparam logic [2:0] MODE_COSINE = 3'd2;

   localparam logic [16:0] WEIGHT_ONE = 17'd65536;

   typedef struct packed {
      logic [2:0]         mode;
      logic [31:0]        length;
      logic signed [31:0] value;
   } key_row_type;

   typedef logic [COS_TABLE_SIZE:0][16:0] ease_table_type;

   // (1 - cos(pi*i/N))/2 in Q0.16 for the first half, by a short Taylor series in Q2.30.
   function automatic logic [16:0] ease_half(input int i);
      logic [63:0]        y;
      logic [63:0]        y2;
      logic [63:0]        prod;
      logic [63:0]        term;
      logic signed [63:0] acc;
      logic signed [63:0] diff;
      y   = (64'd3373259426 * 64'(i)) >> COS_BITS;
      y2  = (y * y) >> 30;
      acc = 64'sd1073741824;
      for (int k = 0; k < 7; k++) begin
         prod = (y2 * 64'(acc)) >> 30;
         case (k)
            0:       term = prod / 182;
            1:       term = prod / 132;
            2:       term = prod / 90;
            3:       term = prod / 56;
            4:       term = prod / 30;
            5:       term = prod / 12;
            default: term = prod / 2;
         endcase
         acc = 64'sd1073741824 - $signed(term);
         if (acc < 0) begin
            acc = 0;
         end
      end
      diff = (64'sd1073741824 - acc + 64'sd16384) >>> 15;
      return diff[16:0];
   endfunction

   function automatic ease_table_type build_ease();
      ease_table_type tab;
      for (int i = 0; i <= COS_TABLE_SIZE; i++) begin
         if (2 * i <= COS_TABLE_SIZE) begin
            tab[i] = ease_half(i);
         end else begin
            tab[i] = WEIGHT_ONE - ease_half(COS_TABLE_SIZE - i);
         end
      end
      return tab;
   endfunction

   localparam ease_table_type EASE_TABLE = build_ease();

endpackage

FILE: hdl/kfsp_req_if.sv
// Request channel of the keyframe sequence player: valid, ready and the request payload.
// Depends on kfsp_pkg for the index width.
interface kfsp_req_if;
   import kfsp_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 opcode;
   logic [KEY_IDX_W-1:0] entry_index;
   logic [31:0]          entry_length;
   logic [2:0]           entry_mode;
   logic signed [31:0]   entry_value;
   logic signed [31:0]   time_step;
   logic [16:0]          blend_factor;

   modport source (output valid, opcode, entry_index, entry_length, entry_mode,
                   entry_value, time_step, blend_factor, input ready);
   modport sink   (input valid, opcode, entry_index, entry_length, entry_mode,
                   entry_value, time_step, blend_factor, output ready);
endinterface

FILE: hdl/kfsp_rsp_if.sv
// Response channel of the keyframe sequence player: valid, ready and the result payload.
// Depends on kfsp_pkg for the index width.
interface kfsp_rsp_if;
   import kfsp_pkg::*;

   logic                 valid;
   logic                 ready;
   logic signed [31:0]   out_value;
   logic [KEY_IDX_W-1:0] segment_now;
   logic                 at_end;

   modport source (output valid, out_value, segment_now, at_end, input ready);
   modport sink   (input valid, out_value, segment_now, at_end, output ready);
endinterface

FILE: hdl/kfsp_key_store.sv
// Keyframe table: one write port and one registered read port.
// Depends on kfsp_pkg for the row type and depth.
module kfsp_key_store (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [kfsp_pkg::KEY_IDX_W-1:0] wr_addr,
   input  kfsp_pkg::key_row_type          wr_data,
   input  logic [kfsp_pkg::KEY_IDX_W-1:0] rd_addr,
   output kfsp_pkg::key_row_type          rd_data
);
   import kfsp_pkg::*;

   key_row_type mem [MAX_KEYFRAMES];
   key_row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: hdl/kfsp_div.sv
// Serial restoring divider for the segment fraction: floor(num * 65536 / den), num <= den.
// Depends on kfsp_pkg only by convention; one quotient bit per cycle.
module kfsp_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] num,
   input  logic [31:0] den,
   output logic        done,
   output logic [16:0] quot
);
   import kfsp_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [16:0] quot_ff, quot_in;
   logic [32:0] shifted;
   logic        take;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      shifted = {rem_ff[31:0], 1'b0};
      take    = shifted >= {1'b0, den_ff};
      if (start) begin
         // The top quotient bit is 0 or 1 because the numerator never exceeds the divisor.
         den_in  = den;
         busy_in = 1'b1;
         cnt_in  = 5'd16;
         if (num >= den) begin
            rem_in  = {1'b0, num - den};
            quot_in = 17'd1;
         end else begin
            rem_in  = {1'b0, num};
            quot_in = 17'd0;
         end
      end else if (busy_ff) begin
         rem_in  = take ? shifted - {1'b0, den_ff} : shifted;
         quot_in = {quot_ff[15:0], take};
         cnt_in  = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
endmodule

FILE: hdl/keyframe_sequence_player_top.sv
// Top level of the keyframe sequence player: sequencer, walk, shared mix multiplier.
// Depends on kfsp_pkg, kfsp_req_if, kfsp_rsp_if, kfsp_key_store and kfsp_div.

// The player holds up to sixteen keyframes (a mode, and length and value in Q16.16) and
// answers each tick transfer with one interpolated, blended value; a write transfer stores
// one keyframe, rewinds playback to segment 0 and produces no response. A tick walks the
// segments one boundary at a time through the single read port of the keyframe table,
// reads the row of the current segment and of the next, runs the one-bit-per-cycle serial
// fraction divider for a linear or cosine segment of nonzero length, and mixes through the
// shared multiplier, once more when the blend factor is below one; a table of one keyframe
// skips the walk and the mix. The request side is not ready while a tick is in progress;
// a finished response sits in an output register, so the next transfer can start while
// the previous response waits.
module keyframe_sequence_player_top (
   input  logic                         clock,
   input  logic                         reset,
   kfsp_req_if.sink                     req_chan,
   kfsp_rsp_if.source                   rsp_chan,
   input  logic                         csr_we,
   input  logic [kfsp_pkg::COUNT_W-1:0] csr_wdata
);
   import kfsp_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_WALK     = 4'd1;
   localparam logic [3:0] S_WALK_ADD = 4'd2;
   localparam logic [3:0] S_WALK_CMP = 4'd3;
   localparam logic [3:0] S_CLAMP    = 4'd4;
   localparam logic [3:0] S_ROW_A    = 4'd5;
   localparam logic [3:0] S_ROW_B    = 4'd6;
   localparam logic [3:0] S_DIV      = 4'd7;
   localparam logic [3:0] S_WEIGHT   = 4'd8;
   localparam logic [3:0] S_MUL      = 4'd9;
   localparam logic [3:0] S_ADD      = 4'd10;
   localparam logic [3:0] S_BLEND    = 4'd11;
   localparam logic [3:0] S_OUT      = 4'd12;

   localparam logic signed [33:0] TIME_MAX = 34'sh0_FFFF_FFFF;

   // Architectural playback state.
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [KEY_IDX_W-1:0] seg_ff, seg_in;
   logic [31:0]          time_ff, time_in;
   logic                 hold_ff, hold_in;
   logic signed [31:0]   prev_ff, prev_in;

   // Working state of the tick in progress.
   logic [3:0]           state_ff, state_in;
   logic [KEY_IDX_W-1:0] s_ff, s_in;
   logic signed [33:0]   t_ff, t_in;
   logic                 hold_w_ff, hold_w_in;
   logic                 neg_ff, neg_in;
   logic                 single_ff, single_in;
   logic [16:0]          blend_ff, blend_in;
   logic [2:0]           mode_ff, mode_in;
   logic [31:0]          len_ff, len_in;
   logic [16:0]          frac_ff, frac_in;
   logic signed [31:0]   value_ff, value_in;
   logic signed [31:0]   op_a_ff, op_a_in;
   logic signed [31:0]   op_b_ff, op_b_in;
   logic [16:0]          op_w_ff, op_w_in;
   logic                 phase_ff, phase_in;
   logic signed [50:0]   prod_ff, prod_in;

   // Response register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]   rsp_value_ff, rsp_value_in;
   logic [KEY_IDX_W-1:0] rsp_seg_ff, rsp_seg_in;
   logic                 rsp_end_ff, rsp_end_in;

   logic [COUNT_W-1:0]   n_eff;
   logic [KEY_IDX_W-1:0] n_last;
   logic                 req_fire;
   logic                 wr_en;
   key_row_type          wr_row;
   logic [KEY_IDX_W-1:0] rd_addr;
   key_row_type          rd_row;
   logic                 div_start;
   logic                 div_done;
   logic [16:0]          div_quot;
   logic signed [32:0]   diff;
   logic signed [34:0]   sum;
   logic signed [31:0]   mix_res;
   logic [COS_BITS:0]    ease_idx;
   logic [COUNT_W-1:0]   s_next;

   kfsp_key_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_chan.entry_index),
      .wr_data (wr_row),
      .rd_addr (rd_addr),
      .rd_data (rd_row)
   );

   kfsp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (t_ff[31:0]),
      .den   (len_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // A count of zero acts as one and a count above the table acts as the full table.
   always_comb begin
      if (count_ff == '0) begin
         n_eff = COUNT_W'(1);
      end else if (count_ff > COUNT_W'(MAX_KEYFRAMES)) begin
         n_eff = COUNT_W'(MAX_KEYFRAMES);
      end else begin
         n_eff = count_ff;
      end
   end
   assign n_last = KEY_IDX_W'(n_eff - COUNT_W'(1));

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign wr_en          = req_fire && (req_chan.opcode == OP_WRITE);
   assign wr_row         = '{mode: req_chan.entry_mode, length: req_chan.entry_length,
                             value: req_chan.entry_value};

   // The mix step: a + floor((b - a) * w / 65536), saturated to 32 bits.
   assign diff = 33'(op_b_ff) - 33'(op_a_ff);
   assign sum  = 35'(op_a_ff) + 35'(prod_ff >>> 16);
   always_comb begin
      if (sum > 35'sd2147483647) begin
         mix_res = 32'sh7FFF_FFFF;
      end else if (sum < -35'sd2147483648) begin
         mix_res = 32'sh8000_0000;
      end else begin
         mix_res = sum[31:0];
      end
   end

   assign ease_idx = frac_ff[16:16-COS_BITS];
   assign s_next   = COUNT_W'(s_ff) + COUNT_W'(1);

   always_comb begin
      count_in     = csr_we ? csr_wdata : count_ff;
      seg_in       = seg_ff;
      time_in      = time_ff;
      hold_in      = hold_ff;
      prev_in      = prev_ff;
      state_in     = state_ff;
      s_in         = s_ff;
      t_in         = t_ff;
      hold_w_in    = hold_w_ff;
      neg_in       = neg_ff;
      single_in    = single_ff;
      blend_in     = blend_ff;
      mode_in      = mode_ff;
      len_in       = len_ff;
      frac_in      = frac_ff;
      value_in     = value_ff;
      op_a_in      = op_a_ff;
      op_b_in      = op_b_ff;
      op_w_in      = op_w_ff;
      phase_in     = phase_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in = rsp_value_ff;
      rsp_seg_in   = rsp_seg_ff;
      rsp_end_in   = rsp_end_ff;
      rd_addr      = s_ff;
      div_start    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_chan.opcode == OP_WRITE) begin
                  seg_in  = '0;
                  time_in = '0;
                  hold_in = 1'b0;
               end else begin
                  single_in = (n_eff == COUNT_W'(1));
                  neg_in    = req_chan.time_step[31];
                  blend_in  = req_chan.blend_factor;
                  t_in      = 34'({2'b00, time_ff}) + 34'(req_chan.time_step);
                  if (n_eff == COUNT_W'(1)) begin
                     s_in     = '0;
                     state_in = S_CLAMP;
                  end else begin
                     // A count that shrank under the position parks playback at the end.
                     if (seg_ff >= n_last) begin
                        s_in      = n_last;
                        hold_w_in = 1'b1;
                     end else begin
                        s_in      = seg_ff;
                        hold_w_in = hold_ff;
                     end
                     state_in = S_WALK;
                  end
               end
            end
         end
         S_WALK: begin
            if (neg_ff) begin
               if (t_ff < 0) begin
                  if (s_ff == '0) begin
                     t_in     = '0;
                     state_in = S_CLAMP;
                  end else begin
                     rd_addr  = s_ff - KEY_IDX_W'(1);
                     s_in     = s_ff - KEY_IDX_W'(1);
                     state_in = S_WALK_ADD;
                  end
               end else begin
                  state_in = S_CLAMP;
               end
            end else if (!hold_w_ff) begin
               state_in = S_WALK_CMP;
            end else begin
               state_in = S_CLAMP;
            end
         end
         S_WALK_ADD: begin
            t_in      = t_ff + 34'({2'b00, rd_row.length});
            hold_w_in = 1'b0;
            state_in  = S_WALK;
         end
         S_WALK_CMP: begin
            if (t_ff > 34'({2'b00, rd_row.length})) begin
               t_in = t_ff - 34'({2'b00, rd_row.length});
               s_in = s_next[KEY_IDX_W-1:0];
               if (s_next >= COUNT_W'(n_last)) begin
                  hold_w_in = 1'b1;
               end
               state_in = S_WALK;
            end else begin
               state_in = S_CLAMP;
            end
         end
         S_CLAMP: begin
            // A held end keeps counting time but saturates it at the largest length.
            if (t_ff > TIME_MAX) begin
               t_in = TIME_MAX;
            end
            state_in = S_ROW_A;
         end
         S_ROW_A: begin
            rd_addr  = s_next[KEY_IDX_W-1:0];
            mode_in  = rd_row.mode;
            len_in   = rd_row.length;
            op_a_in  = rd_row.value;
            value_in = rd_row.value;
            phase_in = 1'b0;
            if (single_ff) begin
               state_in = S_OUT;
            end else if (hold_w_ff) begin
               state_in = S_BLEND;
            end else if (rd_row.mode == MODE_LINEAR || rd_row.mode == MODE_COSINE) begin
               state_in = S_ROW_B;
            end else begin
               state_in = S_BLEND;
            end
         end
         S_ROW_B: begin
            op_b_in = rd_row.value;
            if (len_ff == '0) begin
               frac_in  = '0;
               state_in = S_WEIGHT;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               frac_in  = div_quot;
               state_in = S_WEIGHT;
            end
         end
         S_WEIGHT: begin
            op_w_in  = (mode_ff == MODE_LINEAR) ? frac_ff : EASE_TABLE[ease_idx];
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in  = diff * $signed({1'b0, op_w_ff});
            state_in = S_ADD;
         end
         S_ADD: begin
            value_in = mix_res;
            state_in = phase_ff ? S_OUT : S_BLEND;
         end
         S_BLEND: begin
            if (blend_ff < WEIGHT_ONE) begin
               op_a_in  = prev_ff;
               op_b_in  = value_ff;
               op_w_in  = blend_ff;
               phase_in = 1'b1;
               state_in = S_MUL;
            end else begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = value_ff;
               prev_in      = value_ff;
               if (single_ff) begin
                  rsp_seg_in = '0;
                  rsp_end_in = 1'b1;
               end else begin
                  rsp_seg_in = s_ff;
                  rsp_end_in = hold_w_ff;
                  seg_in     = s_ff;
                  time_in    = t_ff[31:0];
                  hold_in    = hold_w_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= COUNT_RESET;
         seg_ff       <= '0;
         time_ff      <= '0;
         hold_ff      <= 1'b0;
         prev_ff      <= '0;
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         seg_ff       <= seg_in;
         time_ff      <= time_in;
         hold_ff      <= hold_in;
         prev_ff      <= prev_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s_ff         <= s_in;
      t_ff         <= t_in;
      hold_w_ff    <= hold_w_in;
      neg_ff       <= neg_in;
      single_ff    <= single_in;
      blend_ff     <= blend_in;
      mode_ff      <= mode_in;
      len_ff       <= len_in;
      frac_ff      <= frac_in;
      value_ff     <= value_in;
      op_a_ff      <= op_a_in;
      op_b_ff      <= op_b_in;
      op_w_ff      <= op_w_in;
      phase_ff     <= phase_in;
      prod_ff      <= prod_in;
      rsp_value_ff <= rsp_value_in;
      rsp_seg_ff   <= rsp_seg_in;
      rsp_end_ff   <= rsp_end_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_value   = rsp_value_ff;
   assign rsp_chan.segment_now = rsp_seg_ff;
   assign rsp_chan.at_end      = rsp_end_ff;
endmodule
